[src/knn_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// knn_pkg
// Shared types, constants and the controller/datapath interface of the
// k-nearest-neighbor classifier.
// ============================================================================
package knn_pkg;

    localparam int KNN_MAX_SAMPLES = 256;
    localparam int KNN_K           = 5;
    localparam int KNN_FILL_W      = $clog2(KNN_K + 1);
    localparam int KNN_SAMPLE_W    = $clog2(KNN_MAX_SAMPLES);
    localparam int KNN_FEAT_W      = 8;
    localparam int KNN_SQ_W        = 2 * KNN_FEAT_W;
    localparam int KNN_WEIGHT_W    = 15;
    localparam int KNN_TERM_W      = KNN_SQ_W + KNN_WEIGHT_W;
    localparam int KNN_DIST_W      = 34;

    // round(2^24 / range^2), ranges 3.6, 2.4, 5.9, 2.4 cm in tenths
    localparam logic [KNN_WEIGHT_W-1:0] FEATURE_WEIGHT [4] =
        '{15'd12945, 15'd29127, 15'd4820, 15'd29127};

    typedef enum logic [2:0] {
        CFG_QUERY_A     = 3'd0,
        CFG_QUERY_B     = 3'd1,
        CFG_QUERY_C     = 3'd2,
        CFG_QUERY_D     = 3'd3,
        CFG_NEIGH_COUNT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] feature_a;
        logic [7:0] feature_b;
        logic [7:0] feature_c;
        logic [7:0] feature_d;
        logic [1:0] class_label;
        logic       final_sample;
    } sample_t;

    typedef struct packed {
        logic [2:0]            rank;
        logic [7:0]            neighbour_index;
        logic [1:0]            neighbour_label;
        logic [KNN_DIST_W-1:0] distance;
        logic [1:0]            prediction;
        logic                  last_result;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DRAIN,
        ST_INSERT,
        ST_VOTE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load;
        logic       square_en;
        logic [1:0] feat_sel;
        logic       insert;
        logic       vote;
        logic       emit_load;
        logic       clear_list;
    } cmd_t;

    typedef struct packed {
        logic final_sample;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

[src/knn_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// knn_ctrl
// Sequencer: feature-serial distance, list insert, vote and result emission.
// ============================================================================
module knn_ctrl
    import knn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    output cmd_t    cmd,
    input  status_t status
);

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 2'd0;
                if (sample_valid)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                    state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                state_next = status.final_sample ? ST_VOTE : ST_IDLE;
            end
            ST_VOTE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        sample_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                cmd.load     = sample_valid;
            end
            ST_CALC:
            begin
                cmd.square_en = 1'b1;
                cmd.feat_sel  = cnt_reg;
            end
            ST_INSERT:
            begin
                cmd.insert = 1'b1;
            end
            ST_VOTE:
            begin
                cmd.vote = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_load  = status.out_free;
                cmd.clear_list = status.out_free && status.emit_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/knn_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// knn_datapath
// Query registers, shared square/weight pipeline, sorted neighbor list,
// vote and output register.
// ============================================================================
module knn_datapath
    import knn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output status_t    status,
    input  sample_t    sample,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0] query_a_reg, query_b_reg, query_c_reg, query_d_reg;
    logic [2:0] count_reg;

    sample_t                 cur_reg;
    logic [KNN_SQ_W-1:0]     sq_reg, sq_next;
    logic [1:0]              f1_reg;
    logic                    v1_reg, v2_reg;
    logic [KNN_TERM_W-1:0]   term_reg, term_next;
    logic [KNN_DIST_W-1:0]   acc_reg;

    logic [KNN_DIST_W-1:0]   best_dist_reg  [KNN_K];
    logic [KNN_DIST_W-1:0]   best_dist_next [KNN_K];
    logic [7:0]              best_idx_reg   [KNN_K];
    logic [7:0]              best_idx_next  [KNN_K];
    logic [1:0]              best_lab_reg   [KNN_K];
    logic [1:0]              best_lab_next  [KNN_K];
    logic [KNN_FILL_W-1:0]   filled_reg, filled_next;
    logic [KNN_SAMPLE_W-1:0] sample_num_reg;

    logic [KNN_FILL_W-1:0]   k_reg, k_next;
    logic [KNN_FILL_W-1:0]   rank_reg;
    logic [1:0]              pred_reg, pred_next;

    logic                    out_valid_reg;
    result_t                 out_reg, out_next;

    logic [7:0]              x_sel, q_sel, diff;
    logic [KNN_K-1:0]        stay;
    logic [KNN_FILL_W-1:0]   pos;
    logic [KNN_FILL_W-1:0]   k_clamp;
    logic [KNN_FILL_W-1:0]   votes [3];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_a_reg <= '0;
            query_b_reg <= '0;
            query_c_reg <= '0;
            query_d_reg <= '0;
            count_reg   <= 3'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_QUERY_A:     query_a_reg <= cfg_data;
                CFG_QUERY_B:     query_b_reg <= cfg_data;
                CFG_QUERY_C:     query_c_reg <= cfg_data;
                CFG_QUERY_D:     query_d_reg <= cfg_data;
                CFG_NEIGH_COUNT: count_reg   <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // square and weight, one feature per cycle
    always_comb
    begin
        case (cmd.feat_sel)
            2'd0:
            begin
                x_sel = cur_reg.feature_a;
                q_sel = query_a_reg;
            end
            2'd1:
            begin
                x_sel = cur_reg.feature_b;
                q_sel = query_b_reg;
            end
            2'd2:
            begin
                x_sel = cur_reg.feature_c;
                q_sel = query_c_reg;
            end
            default:
            begin
                x_sel = cur_reg.feature_d;
                q_sel = query_d_reg;
            end
        endcase
        diff      = (x_sel >= q_sel) ? (x_sel - q_sel) : (q_sel - x_sel);
        sq_next   = KNN_SQ_W'(diff) * KNN_SQ_W'(diff);
        term_next = KNN_TERM_W'(sq_reg) * KNN_TERM_W'(FEATURE_WEIGHT[f1_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            cur_reg <= sample;
        sq_reg   <= sq_next;
        f1_reg   <= cmd.feat_sel;
        term_reg <= term_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.square_en;
            v2_reg <= v1_reg;
            if (cmd.load)
                acc_reg <= '0;
            else if (v2_reg)
                acc_reg <= acc_reg + KNN_DIST_W'(term_reg);
        end
    end

    // parallel sorted insert; equal distances keep the earlier sample ahead
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < KNN_K; i++)
        begin
            stay[i] = (KNN_FILL_W'(i) < filled_reg) && (best_dist_reg[i] <= acc_reg);
            pos     = pos + KNN_FILL_W'(stay[i]);
        end
        for (int i = 0; i < KNN_K; i++)
        begin
            best_dist_next[i] = best_dist_reg[i];
            best_idx_next[i]  = best_idx_reg[i];
            best_lab_next[i]  = best_lab_reg[i];
            if (!stay[i])
            begin
                if (KNN_FILL_W'(i) == pos)
                begin
                    best_dist_next[i] = acc_reg;
                    best_idx_next[i]  = 8'(sample_num_reg);
                    best_lab_next[i]  = cur_reg.class_label;
                end
                else if (i > 0)
                begin
                    best_dist_next[i] = best_dist_reg[(i > 0) ? i - 1 : 0];
                    best_idx_next[i]  = best_idx_reg[(i > 0) ? i - 1 : 0];
                    best_lab_next[i]  = best_lab_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
        filled_next = (filled_reg < KNN_FILL_W'(KNN_K)) ? filled_reg + 1'b1 : filled_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KNN_K; i++)
            begin
                best_dist_reg[i] <= '1;
                best_idx_reg[i]  <= '0;
                best_lab_reg[i]  <= '0;
            end
            filled_reg     <= '0;
            sample_num_reg <= '0;
        end
        else if (cmd.clear_list)
        begin
            for (int i = 0; i < KNN_K; i++)
            begin
                best_dist_reg[i] <= '1;
                best_idx_reg[i]  <= '0;
                best_lab_reg[i]  <= '0;
            end
            filled_reg     <= '0;
            sample_num_reg <= '0;
        end
        else if (cmd.insert)
        begin
            for (int i = 0; i < KNN_K; i++)
            begin
                best_dist_reg[i] <= best_dist_next[i];
                best_idx_reg[i]  <= best_idx_next[i];
                best_lab_reg[i]  <= best_lab_next[i];
            end
            filled_reg     <= filled_next;
            sample_num_reg <= sample_num_reg + 1'b1;
        end
    end

    // neighbor count and majority vote; label 3 votes for nobody
    always_comb
    begin
        if (count_reg == 3'd0)
            k_clamp = KNN_FILL_W'(1);
        else if (32'(count_reg) > KNN_K)
            k_clamp = KNN_FILL_W'(KNN_K);
        else
            k_clamp = KNN_FILL_W'(count_reg);
        k_next = (k_clamp > filled_reg) ? filled_reg : k_clamp;

        for (int c = 0; c < 3; c++)
            votes[c] = '0;
        for (int i = 0; i < KNN_K; i++)
        begin
            if (KNN_FILL_W'(i) < k_next)
            begin
                case (best_lab_reg[i])
                    2'd0:    votes[0] = votes[0] + 1'b1;
                    2'd1:    votes[1] = votes[1] + 1'b1;
                    2'd2:    votes[2] = votes[2] + 1'b1;
                    default: ;
                endcase
            end
        end
        if (votes[0] >= votes[1] && votes[0] >= votes[2])
            pred_next = 2'd0;
        else if (votes[1] >= votes[2])
            pred_next = 2'd1;
        else
            pred_next = 2'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= KNN_FILL_W'(1);
            rank_reg <= '0;
            pred_reg <= '0;
        end
        else if (cmd.vote)
        begin
            k_reg    <= k_next;
            rank_reg <= '0;
            pred_reg <= pred_next;
        end
        else if (cmd.emit_load)
        begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    // output register
    always_comb
    begin
        out_next.rank            = 3'(rank_reg);
        out_next.neighbour_index = best_idx_reg[rank_reg[$clog2(KNN_K)-1:0]];
        out_next.neighbour_label = best_lab_reg[rank_reg[$clog2(KNN_K)-1:0]];
        out_next.distance        = best_dist_reg[rank_reg[$clog2(KNN_K)-1:0]];
        out_next.prediction      = pred_reg;
        out_next.last_result     = status.emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_load)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
            out_reg <= out_next;
    end

    assign status.final_sample = cur_reg.final_sample;
    assign status.emit_last    = (rank_reg == k_reg - 1'b1);
    assign status.out_free     = !out_valid_reg || !result_stall;
    assign result_valid        = out_valid_reg;
    assign result              = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= KNN_FILL_W'(KNN_K))
    else $error("neighbor list overfilled");

    generate
        for (genvar g = 0; g + 1 < KNN_K; g++)
        begin : g_sorted
            assert property (@(posedge clk) disable iff (!rst_n)
                best_dist_reg[g] <= best_dist_reg[g + 1])
            else $error("neighbor list out of order");
        end
    endgenerate

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (rank_reg < k_reg))
    else $error("emitting beyond neighbor count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load && status.emit_last) |=> (result_valid && result.last_result))
    else $error("last transaction not flagged");

endmodule

[src/knn_classifier.sv]
`timescale 1ns / 1ps
// ============================================================================
// knn_classifier
// k-nearest-neighbor classifier, range-weighted squared Euclidean distance.
// ============================================================================
// Usage:
//   sample channel (sample_valid/sample_stall): one training sample per
//   transaction. A sample passes feature by feature through the shared
//   square/weight multiplier pipeline, which then drains; a parallel insert
//   into the five-entry list follows, and the block returns to idle, where
//   the next sample is accepted. No new sample is taken before then.
//   cfg channel (cfg_valid/cfg_ready): query point and neighbor count, index
//   0..4; ready is always high. Write only while the block is idle.
//   result channel (result_valid/result_stall): after a sample flagged
//   final_sample, a vote step, then k results (rank 0 first), one per
//   cycle while the receiver does not stall; last_result marks the last.
//   A stalled result holds in the output register; the next sample may be
//   accepted as soon as the last result of a query sits in that register.
//   Reset: query 0, neighbor count 1, empty list, sample numbering at 0.
// ============================================================================
module knn_classifier
    import knn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_stall,
    input  sample_t    sample,
    output logic       result_valid,
    input  logic       result_stall,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    knn_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .status       (status)
    );

    knn_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule
